@@ hdl/grc_pkg.sv @@
`default_nettype none
package grc_pkg;

  // Map and texture geometry.
  localparam int MAP_SIZE  = 64;
  localparam int MAP_W     = $clog2(MAP_SIZE);
  localparam int MAP_DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int ADDR_W    = 2 * MAP_W;
  localparam int MC_W      = MAP_W + 2;
  localparam int TEX_SIZE  = 64;
  localparam int TEX_W     = $clog2(TEX_SIZE);
  localparam int MAX_STEPS = 128;
  localparam int N_W       = $clog2(MAX_STEPS);
  localparam int CELL_MAX  = 8;

  // Fixed-point limits.
  localparam int Q_ONE = 65536;
  localparam int SAT22 = 4194303;
  localparam int SAT24 = 16777215;

  // Shared divider widths.
  localparam int DVD_W = 33;
  localparam int DVS_W = 48;
  localparam int CNT_W = $clog2(DVD_W);

  // Configuration register indexes.
  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;
  localparam logic [2:0] REG_COLS    = 3'd6;
  localparam logic [2:0] REG_ROWS    = 3'd7;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DIV_CAM, S_RAY_MUL, S_RAY_ADD, S_DIV_DX, S_DIV_DY,
    S_SIDE, S_STEP, S_CHECK, S_PERP, S_WALL, S_DIV_LH, S_SPAN, S_DIV_TS,
    S_START, S_FIN, S_MISS
  } state_e;

  typedef enum logic [2:0] {
    DSEL_CAM, DSEL_DX, DSEL_DY, DSEL_LH, DSEL_TS
  } div_sel_e;

  typedef struct packed {
    logic     clear_wr;
    logic     map_wr;
    logic     accept_cast;
    logic     div_start;
    div_sel_e div_sel;
    logic     ray_mul;
    logic     ray_add;
    logic     dx_inf;
    logic     dy_inf;
    logic     side_init;
    logic     step;
    logic     check_inc;
    logic     hit_lat;
    logic     perp;
    logic     wall;
    logic     lh_rows;
    logic     span;
    logic     ts_sat;
    logic     start;
    logic     out_hit;
    logic     out_miss;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic rdx_zero;
    logic rdy_zero;
    logic step_oob;
    logic cell_hit;
    logic steps_last;
    logic perp_zero;
    logic lh_zero;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ hdl/grc_div.sv @@
`default_nettype none
module grc_div import grc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quot_o
);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W:0]   rem_q, rem_d, trial;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic             ge;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      rem_d = ge ? trial - {1'b0, dvs_q} : trial;
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i && !done_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

@@ hdl/grc_dp.sv @@
`default_nettype none
module grc_dp import grc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output status_t          status_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [21:0] cfg_wdata_i,
  input  wire logic [31:0] in_data_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [9:0]       draw_start_o,
  output logic [9:0]       draw_end_o,
  output logic [2:0]       wall_texture_o,
  output logic [5:0]       texture_col_o,
  output logic             hit_side_o,
  output logic [23:0]      perp_dist_o,
  output logic [21:0]      tex_step_o,
  output logic [21:0]      tex_start_o,
  output logic             no_hit_o
);

  // Configuration registers.
  logic [21:0] pos_x_q, pos_y_q;
  logic [18:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [9:0]  cols_q, rows_q, cols_eff, rows_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= 22'd1474560;
      pos_y_q   <= 22'd753664;
      dir_x_q   <= 19'h70000;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= 19'd43254;
      cols_q    <= 10'd320;
      rows_q    <= 10'd240;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_POS_X:   pos_x_q   <= cfg_wdata_i;
        REG_POS_Y:   pos_y_q   <= cfg_wdata_i;
        REG_DIR_X:   dir_x_q   <= cfg_wdata_i[18:0];
        REG_DIR_Y:   dir_y_q   <= cfg_wdata_i[18:0];
        REG_PLANE_X: plane_x_q <= cfg_wdata_i[18:0];
        REG_PLANE_Y: plane_y_q <= cfg_wdata_i[18:0];
        REG_COLS:    cols_q    <= cfg_wdata_i[9:0];
        REG_ROWS:    rows_q    <= cfg_wdata_i[9:0];
        default:     ;
      endcase
    end
  end

  // A zero screen size counts as one.
  assign cols_eff = (cols_q == '0) ? 10'd1 : cols_q;
  assign rows_eff = (rows_q == '0) ? 10'd1 : rows_q;

  // Input fields.
  logic [9:0]       in_column;
  logic [MAP_W-1:0] in_cell_x, in_cell_y;
  logic [3:0]       in_cell_value, cell_wr;
  assign in_column     = in_data_i[9:0];
  assign in_cell_x     = in_data_i[15:10];
  assign in_cell_y     = in_data_i[21:16];
  assign in_cell_value = in_data_i[25:22];
  assign cell_wr = (in_cell_value > 4'(CELL_MAX)) ? 4'(CELL_MAX) : in_cell_value;

  // Clearing sweep counter.
  logic [ADDR_W-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_wr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Ray state.
  logic [9:0]         column_q;
  logic signed [27:0] camx_q;
  logic signed [46:0] prodx_q, prody_q;
  logic signed [32:0] rdx_q, rdy_q;
  logic [32:0]        rdx_abs, rdy_abs;
  logic [40:0]        dx_q, dy_q;
  logic [47:0]        sdx_q, sdy_q, perp_q;
  logic [MC_W-1:0]    mx_q, my_q, mx_nx, my_nx;
  logic               side_q;
  logic [N_W-1:0]     n_q;
  logic [3:0]         rd_q, hit_val_q;
  logic [31:0]        wprod_q;
  logic [9:0]         lh_q, ds_q, de_q;
  logic signed [11:0] term_q;
  logic [21:0]        step_q, start_q;

  assign rdx_abs = rdx_q[32] ? 33'(-rdx_q) : 33'(rdx_q);
  assign rdy_abs = rdy_q[32] ? 33'(-rdy_q) : 33'(rdy_q);

  // Divider operand selection.
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic             div_done;
  logic [DVD_W-1:0] quot;

  always_comb begin
    unique case (cmd_i.div_sel)
      DSEL_CAM: begin
        dvd = DVD_W'({column_q, 17'b0});
        dvs = DVS_W'(cols_eff);
      end
      DSEL_DX: begin
        dvd = DVD_W'(64'h1_0000_0000);
        dvs = DVS_W'(rdx_abs);
      end
      DSEL_DY: begin
        dvd = DVD_W'(64'h1_0000_0000);
        dvs = DVS_W'(rdy_abs);
      end
      DSEL_LH: begin
        dvd = DVD_W'({rows_eff, 16'b0});
        dvs = perp_q;
      end
      DSEL_TS: begin
        dvd = DVD_W'(TEX_SIZE * Q_ONE);
        dvs = DVS_W'(lh_q);
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  grc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Side distance set-up products.
  logic [16:0] fsel_x, fsel_y;
  logic [49:0] sprod_x, sprod_y;
  assign fsel_x  = rdx_q[32] ? {1'b0, pos_x_q[15:0]} : 17'(Q_ONE) - {1'b0, pos_x_q[15:0]};
  assign fsel_y  = rdy_q[32] ? {1'b0, pos_y_q[15:0]} : 17'(Q_ONE) - {1'b0, pos_y_q[15:0]};
  assign sprod_x = fsel_x * dx_q[32:0];
  assign sprod_y = fsel_y * dy_q[32:0];

  // One grid step: pick the nearer side and move the map cell.
  logic x_sel;
  assign x_sel = sdx_q < sdy_q;
  assign mx_nx = !x_sel ? mx_q : (rdx_q[32] ? mx_q - 1'b1 : mx_q + 1'b1);
  assign my_nx =  x_sel ? my_q : (rdy_q[32] ? my_q - 1'b1 : my_q + 1'b1);

  // Span of the wall on screen.
  logic [9:0]  half, l2;
  logic [10:0] de_sum;
  assign half   = rows_eff >> 1;
  assign l2     = lh_q >> 1;
  assign de_sum = {1'b0, half} + {1'b0, l2};

  // Texture start product.
  logic signed [34:0] st_prod;
  assign st_prod = term_q * $signed({1'b0, step_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_cast) begin
      column_q <= in_column;
    end
    if (div_done) begin
      unique case (cmd_i.div_sel)
        DSEL_CAM: camx_q <= $signed({1'b0, quot[26:0]}) - 28'sd65536;
        DSEL_DX:  dx_q   <= 41'(quot);
        DSEL_DY:  dy_q   <= 41'(quot);
        DSEL_LH:  lh_q   <= (quot > DVD_W'(rows_eff)) ? rows_eff : quot[9:0];
        DSEL_TS:  step_q <= (quot > DVD_W'(SAT22)) ? 22'(SAT22) : quot[21:0];
        default:  ;
      endcase
    end
    if (cmd_i.ray_mul) begin
      prodx_q <= $signed(plane_x_q) * camx_q;
      prody_q <= $signed(plane_y_q) * camx_q;
    end
    if (cmd_i.ray_add) begin
      rdx_q <= 33'($signed(dir_x_q)) + 33'(prodx_q >>> 16);
      rdy_q <= 33'($signed(dir_y_q)) + 33'(prody_q >>> 16);
    end
    if (cmd_i.dx_inf) begin
      dx_q <= 41'h100_0000_0000;
    end
    if (cmd_i.dy_inf) begin
      dy_q <= 41'h100_0000_0000;
    end
    if (cmd_i.side_init) begin
      sdx_q <= dx_q[40] ? (48'(fsel_x) << 24) : 48'(sprod_x >> 16);
      sdy_q <= dy_q[40] ? (48'(fsel_y) << 24) : 48'(sprod_y >> 16);
      mx_q  <= MC_W'(pos_x_q[21:16]);
      my_q  <= MC_W'(pos_y_q[21:16]);
      n_q   <= '0;
    end
    if (cmd_i.step) begin
      if (x_sel) begin
        sdx_q <= sdx_q + 48'(dx_q);
      end else begin
        sdy_q <= sdy_q + 48'(dy_q);
      end
      mx_q   <= mx_nx;
      my_q   <= my_nx;
      side_q <= !x_sel;
    end
    if (cmd_i.check_inc) begin
      n_q <= n_q + 1'b1;
    end
    if (cmd_i.hit_lat) begin
      hit_val_q <= rd_q;
    end
    if (cmd_i.perp) begin
      perp_q <= side_q ? sdy_q - 48'(dy_q) : sdx_q - 48'(dx_q);
    end
    if (cmd_i.wall) begin
      wprod_q <= 32'(perp_q[31:0] * (side_q ? rdx_q[31:0] : rdy_q[31:0]));
    end
    if (cmd_i.lh_rows) begin
      lh_q <= rows_eff;
    end
    if (cmd_i.span) begin
      ds_q   <= (l2 > half) ? '0 : half - l2;
      de_q   <= (de_sum >= {1'b0, rows_eff}) ? rows_eff - 1'b1 : de_sum[9:0];
      term_q <= $signed({2'b0, ((l2 > half) ? 10'd0 : half - l2)})
                - $signed({2'b0, half}) + $signed({2'b0, l2});
    end
    if (cmd_i.ts_sat) begin
      step_q <= 22'(SAT22);
    end
    if (cmd_i.start) begin
      if (lh_q == '0 || st_prod < 0) begin
        start_q <= '0;
      end else if (st_prod > 35'sd4194303) begin
        start_q <= 22'(SAT22);
      end else begin
        start_q <= st_prod[21:0];
      end
    end
  end

  // Map memory: sweep clear, item writes, one registered read a cycle.
  logic [3:0]        map_mem [MAP_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [3:0]        mem_wdata;
  assign mem_we    = cmd_i.clear_wr || cmd_i.map_wr;
  assign mem_waddr = cmd_i.clear_wr ? clr_q : {in_cell_x, in_cell_y};
  assign mem_wdata = cmd_i.clear_wr ? 4'd0 : cell_wr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= map_mem[{mx_nx[MAP_W-1:0], my_nx[MAP_W-1:0]}];
  end

  // Texture column from the wall hit fraction.
  logic [15:0]      wall_frac;
  logic [TEX_W-1:0] texx;
  logic             flip;
  assign wall_frac = (side_q ? pos_x_q[15:0] : pos_y_q[15:0]) + wprod_q[31:16];
  assign flip      = side_q ? rdy_q[32] : (!rdx_q[32] && rdx_q != '0);
  assign texx      = flip ? TEX_W'(TEX_SIZE - 1) - wall_frac[15 -: TEX_W]
                          : wall_frac[15 -: TEX_W];

  // Output register.
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_hit || cmd_i.out_miss) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_hit) begin
      draw_start_o   <= ds_q;
      draw_end_o     <= de_q;
      wall_texture_o <= 3'(hit_val_q - 1'b1);
      texture_col_o  <= 6'(texx);
      hit_side_o     <= side_q;
      perp_dist_o    <= (perp_q > 48'(SAT24)) ? 24'(SAT24) : perp_q[23:0];
      tex_step_o     <= step_q;
      tex_start_o    <= start_q;
      no_hit_o       <= 1'b0;
    end else if (cmd_i.out_miss) begin
      draw_start_o   <= '0;
      draw_end_o     <= '0;
      wall_texture_o <= '0;
      texture_col_o  <= '0;
      hit_side_o     <= 1'b0;
      perp_dist_o    <= '0;
      tex_step_o     <= '0;
      tex_start_o    <= '0;
      no_hit_o       <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller.
  always_comb begin
    status_o.clear_last = clr_q == ADDR_W'(MAP_DEPTH - 1);
    status_o.div_done   = div_done;
    status_o.rdx_zero   = rdx_q == '0;
    status_o.rdy_zero   = rdy_q == '0;
    status_o.step_oob   = (|mx_nx[MC_W-1:MAP_W]) || (|my_nx[MC_W-1:MAP_W]);
    status_o.cell_hit   = rd_q != '0;
    status_o.steps_last = n_q == N_W'(MAX_STEPS - 1);
    status_o.perp_zero  = perp_q == '0;
    status_o.lh_zero    = lh_q == '0;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Divisors are never zero when a division starts.
  a_dx_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_start && cmd_i.div_sel == DSEL_DX) |-> rdx_q != '0)
    else $error("reciprocal started on a zero x ray component");
  a_lh_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_start && cmd_i.div_sel == DSEL_LH) |-> perp_q != '0)
    else $error("line height division started with zero distance");
  a_ts_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_start && cmd_i.div_sel == DSEL_TS) |-> lh_q != '0)
    else $error("texture step division started with zero line height");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_hit || cmd_i.out_miss) |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over one not yet taken");

endmodule
`default_nettype wire

@@ hdl/grc_ctrl.sv @@
`default_nettype none
module grc_ctrl import grc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire status_t status_i,
  input  wire logic    in_valid_i,
  input  wire logic    in_op_i,
  output logic         in_ready_o,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:   if (status_i.clear_last) state_d = S_IDLE;
      S_IDLE:    if (in_valid_i && !in_op_i) state_d = S_DIV_CAM;
      S_DIV_CAM: if (status_i.div_done) state_d = S_RAY_MUL;
      S_RAY_MUL: state_d = S_RAY_ADD;
      S_RAY_ADD: state_d = S_DIV_DX;
      S_DIV_DX:  if (status_i.rdx_zero || status_i.div_done) state_d = S_DIV_DY;
      S_DIV_DY:  if (status_i.rdy_zero || status_i.div_done) state_d = S_SIDE;
      S_SIDE:    state_d = S_STEP;
      S_STEP:    state_d = status_i.step_oob ? S_MISS : S_CHECK;
      S_CHECK: begin
        if (status_i.cell_hit) begin
          state_d = S_PERP;
        end else if (status_i.steps_last) begin
          state_d = S_MISS;
        end else begin
          state_d = S_STEP;
        end
      end
      S_PERP:    state_d = S_WALL;
      S_WALL:    state_d = status_i.perp_zero ? S_SPAN : S_DIV_LH;
      S_DIV_LH:  if (status_i.div_done) state_d = S_SPAN;
      S_SPAN:    state_d = status_i.lh_zero ? S_START : S_DIV_TS;
      S_DIV_TS:  if (status_i.div_done) state_d = S_START;
      S_START:   state_d = S_FIN;
      S_FIN:     if (status_i.out_free) state_d = S_IDLE;
      S_MISS:    if (status_i.out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DSEL_CAM;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.clear_wr = 1'b1;
      S_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.map_wr      = in_valid_i && in_op_i;
        cmd_o.accept_cast = in_valid_i && !in_op_i;
      end
      S_DIV_CAM: cmd_o.div_start = 1'b1;
      S_RAY_MUL: cmd_o.ray_mul = 1'b1;
      S_RAY_ADD: cmd_o.ray_add = 1'b1;
      S_DIV_DX: begin
        cmd_o.div_sel   = DSEL_DX;
        cmd_o.dx_inf    = status_i.rdx_zero;
        cmd_o.div_start = !status_i.rdx_zero;
      end
      S_DIV_DY: begin
        cmd_o.div_sel   = DSEL_DY;
        cmd_o.dy_inf    = status_i.rdy_zero;
        cmd_o.div_start = !status_i.rdy_zero;
      end
      S_SIDE:  cmd_o.side_init = 1'b1;
      S_STEP:  cmd_o.step = 1'b1;
      S_CHECK: begin
        cmd_o.hit_lat   = status_i.cell_hit;
        cmd_o.check_inc = !status_i.cell_hit;
      end
      S_PERP:  cmd_o.perp = 1'b1;
      S_WALL: begin
        cmd_o.wall    = 1'b1;
        cmd_o.lh_rows = status_i.perp_zero;
      end
      S_DIV_LH: begin
        cmd_o.div_sel   = DSEL_LH;
        cmd_o.div_start = 1'b1;
      end
      S_SPAN: begin
        cmd_o.span   = 1'b1;
        cmd_o.ts_sat = status_i.lh_zero;
      end
      S_DIV_TS: begin
        cmd_o.div_sel   = DSEL_TS;
        cmd_o.div_start = 1'b1;
      end
      S_START: cmd_o.start = 1'b1;
      S_FIN:   cmd_o.out_hit = status_i.out_free;
      S_MISS:  cmd_o.out_miss = status_i.out_free;
      default: ;
    endcase
  end

  // Items are refused during the clearing sweep.
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !cmd_o.map_wr && !cmd_o.accept_cast)
    else $error("item taken during map clear");
  a_cast_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept_cast |=> state_q == S_DIV_CAM)
    else $error("accepted cast did not start the camera division");
  a_step_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> $past(state_q) == S_STEP)
    else $error("cell check without a preceding step");

endmodule
`default_nettype wire

@@ hdl/grid_raycast_column.sv @@
`default_nettype none
// Column ray caster over a 64 x 64 grid of wall cells. A write item (tuser
// high) stores one cell and leaves the block idle for the next item. A cast
// item (tuser low) walks the ray for one screen column and returns one
// result; tuser of the result is high when no wall was met. A cast crosses
// at most 128 grid cells; up to five divisions go through one shared restoring
// divider, and each grid step needs one read of the map memory. The next
// request is taken in the cycle after the result is loaded. A result left
// waiting on m_axis_tready holds the block. After reset the 4096 cells of the
// map are cleared by a sweep, during which no item is accepted; configuration
// writes are taken at any time.
module grid_raycast_column import grc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_addr_i,
  input  wire logic [21:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // column[9:0], cell_x[15:10], cell_y[21:16], cell_value[25:22], zero pad
  input  wire logic [31:0]  s_axis_tdata,
  // op[0]
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // draw_start[9:0], draw_end[19:10], wall_texture[22:20], texture_col[28:23],
  // hit_side[29], perp_dist[53:30], tex_step[75:54], tex_start[97:76], zero pad
  output logic [103:0]      m_axis_tdata,
  // no_hit[0]
  output logic [0:0]        m_axis_tuser
);

  cmd_t    cmd;
  status_t status;

  logic [9:0]  draw_start, draw_end;
  logic [2:0]  wall_texture;
  logic [5:0]  texture_col;
  logic        hit_side, no_hit;
  logic [23:0] perp_dist;
  logic [21:0] tex_step, tex_start;

  grc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  grc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_data_i      (s_axis_tdata),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .draw_start_o   (draw_start),
    .draw_end_o     (draw_end),
    .wall_texture_o (wall_texture),
    .texture_col_o  (texture_col),
    .hit_side_o     (hit_side),
    .perp_dist_o    (perp_dist),
    .tex_step_o     (tex_step),
    .tex_start_o    (tex_start),
    .no_hit_o       (no_hit)
  );

  // Pack the result fields, lowest first.
  assign m_axis_tdata = {6'b0, tex_start, tex_step, perp_dist, hit_side,
                         texture_col, wall_texture, draw_end, draw_start};
  assign m_axis_tuser = no_hit;

endmodule
`default_nettype wire

@@ test/grc_column_checker.sv @@
`timescale 1ns / 100ps
// Watches the configuration port and both streams of the column ray caster.
// It keeps its own copy of the registers and of the map, works out the result
// of every cast request and compares it with what the block returns.
module grc_column_checker import grc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_addr_i,
  input  wire logic [21:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,
  input  wire logic [0:0]   s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [103:0] m_axis_tdata,
  input  wire logic [0:0]   m_axis_tuser,
  output int                mismatches_o,
  output int                pending_o
);

  typedef longint unsigned u64_t;

  typedef struct {
    logic [9:0]  draw_start;
    logic [9:0]  draw_end;
    logic [2:0]  wall_texture;
    logic [5:0]  texture_col;
    logic        hit_side;
    logic [23:0] perp_dist;
    logic [21:0] tex_step;
    logic [21:0] tex_start;
    logic        no_hit;
  } column_span_t;

  logic [21:0]        pos_x, pos_y;
  logic signed [18:0] dir_x, dir_y, plane_x, plane_y;
  logic [9:0]         screen_cols, screen_rows;
  logic [3:0]         map_cells [MAP_DEPTH];
  column_span_t       column_spans_q [$];
  int                 mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Distance along the ray between two grid lines of one axis.
  function automatic longint unsigned cell_delta(longint ray);
    longint unsigned mag;
    mag = (ray < 0) ? longint'(-ray) : ray;
    return (mag != 0) ? (64'd1 << 32) / mag : (64'd1 << 40);
  endfunction

  // Walks the ray of one screen column through the map and forms its span.
  function automatic column_span_t cast_column(logic [9:0] column);
    longint unsigned cols, rows, fx, fy, dx, dy, sdx, sdy, perp, lh, wall, texx, tstep;
    longint          camx, rdx, rdy, mx, my, sx, sy, ds, de, half, term, tstart;
    logic            hit, side;
    logic [3:0]      cell_val;
    column_span_t    r;
    r = '{default: '0};
    hit = 1'b0;
    side = 1'b0;
    cell_val = '0;
    cols = (screen_cols == 0) ? 1 : screen_cols;
    rows = (screen_rows == 0) ? 1 : screen_rows;
    camx = longint'((u64_t'(column) * 2 * Q_ONE) / cols) - Q_ONE;
    rdx = longint'(dir_x) + ((longint'(plane_x) * camx) >>> 16);
    rdy = longint'(dir_y) + ((longint'(plane_y) * camx) >>> 16);
    dx = cell_delta(rdx);
    dy = cell_delta(rdy);
    mx = pos_x >> 16;
    my = pos_y >> 16;
    fx = pos_x & 16'hFFFF;
    fy = pos_y & 16'hFFFF;
    if (rdx < 0) begin
      sx = -1;
      sdx = (fx * dx) >> 16;
    end else begin
      sx = 1;
      sdx = ((Q_ONE - fx) * dx) >> 16;
    end
    if (rdy < 0) begin
      sy = -1;
      sdy = (fy * dy) >> 16;
    end else begin
      sy = 1;
      sdy = ((Q_ONE - fy) * dy) >> 16;
    end
    // Step cell by cell; the starting cell itself is never tested.
    for (int n = 0; n < MAX_STEPS; n++) begin
      if (sdx < sdy) begin
        sdx += dx;
        mx += sx;
        side = 1'b0;
      end else begin
        sdy += dy;
        my += sy;
        side = 1'b1;
      end
      if (mx < 0 || mx >= MAP_SIZE || my < 0 || my >= MAP_SIZE) break;
      cell_val = map_cells[mx * MAP_SIZE + my];
      if (cell_val != 0) begin
        hit = 1'b1;
        break;
      end
    end
    if (!hit) begin
      r.no_hit = 1'b1;
      return r;
    end
    perp = side ? sdy - dy : sdx - dx;
    if (perp == 0) begin
      lh = rows;
    end else begin
      lh = (rows << 16) / perp;
      if (lh > rows) lh = rows;
    end
    half = rows / 2;
    ds = half - longint'(lh / 2);
    if (ds < 0) ds = 0;
    de = half + longint'(lh / 2);
    if (de >= longint'(rows)) de = rows - 1;
    // Point where the wall was struck, taken modulo one cell.
    if (!side) wall = (pos_y + ((perp * u64_t'(rdy)) >> 16)) & 16'hFFFF;
    else wall = (pos_x + ((perp * u64_t'(rdx)) >> 16)) & 16'hFFFF;
    texx = (wall * TEX_SIZE) >> 16;
    if ((!side && rdx > 0) || (side && rdy < 0)) texx = TEX_SIZE - 1 - texx;
    tstep = (lh != 0) ? (u64_t'(TEX_SIZE) << 16) / lh : SAT22;
    tstart = 0;
    if (lh != 0) begin
      term = ds - half + longint'(lh / 2);
      tstart = term * longint'(tstep);
      if (tstart < 0) tstart = 0;
      if (tstart > SAT22) tstart = SAT22;
    end
    r.draw_start   = ds[9:0];
    r.draw_end     = de[9:0];
    r.wall_texture = 3'(cell_val - 1);
    r.texture_col  = texx[5:0];
    r.hit_side     = side;
    r.perp_dist    = (perp > SAT24) ? 24'(SAT24) : perp[23:0];
    r.tex_step     = (tstep > SAT22) ? 22'(SAT22) : tstep[21:0];
    r.tex_start    = tstart[21:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    column_span_t want;
    logic [3:0]   value;
    if (!rst_ni) begin
      pos_x <= 22'd1474560;
      pos_y <= 22'd753664;
      dir_x <= -19'sd65536;
      dir_y <= '0;
      plane_x <= '0;
      plane_y <= 19'sd43254;
      screen_cols <= 10'd320;
      screen_rows <= 10'd240;
      for (int i = 0; i < MAP_DEPTH; i++) map_cells[i] = '0;
      column_spans_q.delete();
      pending_o <= 0;
    end else begin
      // Register writes.
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_POS_X:   pos_x <= cfg_wdata_i;
          REG_POS_Y:   pos_y <= cfg_wdata_i;
          REG_DIR_X:   dir_x <= cfg_wdata_i[18:0];
          REG_DIR_Y:   dir_y <= cfg_wdata_i[18:0];
          REG_PLANE_X: plane_x <= cfg_wdata_i[18:0];
          REG_PLANE_Y: plane_y <= cfg_wdata_i[18:0];
          REG_COLS:    screen_cols <= cfg_wdata_i[9:0];
          REG_ROWS:    screen_rows <= cfg_wdata_i[9:0];
          default: ;
        endcase
      end
      // Accepted requests: map writes update the copy, casts are predicted.
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0]) begin
          value = s_axis_tdata[25:22];
          map_cells[{s_axis_tdata[15:10], s_axis_tdata[21:16]}] =
            (value > CELL_MAX) ? 4'(CELL_MAX) : value;
        end else begin
          column_spans_q.push_back(cast_column(s_axis_tdata[9:0]));
        end
      end
      // Returned results against the oldest prediction.
      if (m_axis_tvalid && m_axis_tready) begin
        if (column_spans_q.size() == 0) begin
          report_mismatch("outstanding casts", 0, 1);
        end else begin
          want = column_spans_q.pop_front();
          if (m_axis_tdata[9:0] !== want.draw_start)
            report_mismatch("draw_start", m_axis_tdata[9:0], want.draw_start);
          if (m_axis_tdata[19:10] !== want.draw_end)
            report_mismatch("draw_end", m_axis_tdata[19:10], want.draw_end);
          if (m_axis_tdata[22:20] !== want.wall_texture)
            report_mismatch("wall_texture", m_axis_tdata[22:20], want.wall_texture);
          if (m_axis_tdata[28:23] !== want.texture_col)
            report_mismatch("texture_col", m_axis_tdata[28:23], want.texture_col);
          if (m_axis_tdata[29] !== want.hit_side)
            report_mismatch("hit_side", m_axis_tdata[29], want.hit_side);
          if (m_axis_tdata[53:30] !== want.perp_dist)
            report_mismatch("perp_dist", m_axis_tdata[53:30], want.perp_dist);
          if (m_axis_tdata[75:54] !== want.tex_step)
            report_mismatch("tex_step", m_axis_tdata[75:54], want.tex_step);
          if (m_axis_tdata[97:76] !== want.tex_start)
            report_mismatch("tex_start", m_axis_tdata[97:76], want.tex_start);
          if (m_axis_tuser[0] !== want.no_hit)
            report_mismatch("no_hit", m_axis_tuser[0], want.no_hit);
        end
      end
      pending_o <= column_spans_q.size();
    end
  end

endmodule

@@ test/tb_grid_raycast_column.sv @@
`timescale 1ns / 100ps
// Drives map writes, casts and register settings into the column ray caster,
// stalls both streams at random and reports the outcome of the checker.
module tb_grid_raycast_column import grc_pkg::*;;

  localparam int STALL_MAX   = 18;
  localparam int IDLE_LIMIT  = 20000;
  localparam int PHASE_ITEMS = 240;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_addr_i = '0;
  logic [21:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  int           mismatches, pending;
  int           idle_cycles = 0;
  bit           send_burst = 1'b0;
  bit           recv_burst = 1'b0;
  int           cam_cx = 22, cam_cy = 11;
  int           cols_now = 320;

  localparam logic OP_CAST  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  grid_raycast_column dut (.*);

  grc_column_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .mismatches_o(mismatches), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog on cycles in which no request and no result moves.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("grid_raycast_column verification failed");
        $finish;
      end
    end
  end

  // Result side: a random stall before each result, with stall-free stretches.
  initial begin
    int gap;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 40) == 0) recv_burst = ~recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, STALL_MAX);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send(logic op, logic [31:0] data);
    int gap;
    if ($urandom_range(0, 30) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_cell(int x, int y, int value);
    send(OP_WRITE, {6'd0, 4'(value), 6'(y), 6'(x), 10'd0});
  endtask

  task automatic cast(int column);
    send(OP_CAST, {22'd0, 10'(column)});
  endtask

  // Let every outstanding cast return, with the request side idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [21:0] value);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  function automatic logic [21:0] rand_vec();
    return 22'($signed($urandom_range(0, 262144)) - 131072);
  endfunction

  task automatic set_view(int px, int py, int dx, int dy, int plx, int ply,
                          int cols, int rows);
    drain();
    repeat (20) @(posedge clk_i);
    write_reg(REG_POS_X, 22'(px));
    write_reg(REG_POS_Y, 22'(py));
    write_reg(REG_DIR_X, 22'(dx));
    write_reg(REG_DIR_Y, 22'(dy));
    write_reg(REG_PLANE_X, 22'(plx));
    write_reg(REG_PLANE_Y, 22'(ply));
    write_reg(REG_COLS, 22'(cols));
    write_reg(REG_ROWS, 22'(rows));
    cfg_we_i <= 1'b0;
    cam_cx = px >> 16;
    cam_cy = py >> 16;
    cols_now = (cols == 0) ? 1 : cols;
  endtask

  // Mostly walls near the camera so that rays hit, plus casts across the screen.
  task automatic run_phase();
    int x, y, value;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        if ($urandom_range(0, 3) != 0) begin
          x = cam_cx + $signed($urandom_range(0, 16)) - 8;
          y = cam_cy + $signed($urandom_range(0, 16)) - 8;
          if (x < 0) x = 0;
          if (x > 63) x = 63;
          if (y < 0) y = 0;
          if (y > 63) y = 63;
        end else begin
          x = $urandom_range(0, 63);
          y = $urandom_range(0, 63);
        end
        value = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        write_cell(x, y, value);
      end else if ($urandom_range(0, 9) == 0) begin
        cast($urandom_range(0, 1023));
      end else begin
        cast($urandom_range(0, cols_now - 1));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the settings after reset.
    cast(160);
    write_cell(10, 11, 3);
    write_cell(0, 0, 15);
    write_cell(63, 63, 8);
    write_cell(21, 10, 2);
    write_cell(21, 12, 5);
    write_cell(18, 14, 1);
    write_cell(18, 8, 7);
    write_cell(5, 5, 0);
    cast(0);
    cast(160);
    cast(319);
    cast(1022);
    cast(1023);
    cast(100);
    // Hold off until every cast has returned.
    drain();
    write_cell(10, 11, 0);
    cast(160);
    cast(50);

    // Extreme settings first, then random ones.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_view(0, 0, 131072, 131072, -131072, 0, 0, 0);
        1: set_view(4194303, 4194303, -131072, -131072, 131072, 131072, 1023, 1023);
        2: set_view(32 << 16, 32 << 16, 0, 0, 0, 0, 1, 1);
        default: set_view($urandom_range(1 << 16, (63 << 16) - 1),
                          $urandom_range(1 << 16, (63 << 16) - 1),
                          rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                          $urandom_range(1, 1023), $urandom_range(1, 1023));
      endcase
      run_phase();
    end

    drain();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("grid_raycast_column verification clean");
    end else begin
      $display("grid_raycast_column verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/grc_pkg.sv
hdl/grc_div.sv
hdl/grc_dp.sv
hdl/grc_ctrl.sv
hdl/grid_raycast_column.sv
test/grc_column_checker.sv
test/tb_grid_raycast_column.sv
